### src/bvre_pkg.sv
package bvre_pkg;

	localparam int MaxBits    = 1024;
	localparam int StoreBytes = (MaxBits + 7) / 8;
	localparam int AddrW      = $clog2(StoreBytes);
	localparam int IdxW       = 10;
	localparam int LenW       = 11;
	localparam int PopW       = 11;
	localparam int PaddrW     = 3;

	localparam logic [2:0] KIND_GET    = 3'd0;
	localparam logic [2:0] KIND_PUT    = 3'd1;
	localparam logic [2:0] KIND_CLEAR  = 3'd2;
	localparam logic [2:0] KIND_SET    = 3'd3;
	localparam logic [2:0] KIND_INVERT = 3'd4;
	localparam logic [2:0] KIND_COUNT  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_STEP,
		ST_FINISH
	} state_t;

	function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, b[i]};
		end
		return c;
	endfunction

endpackage

### src/bvre_ram.sv
module bvre_ram #(
	parameter int Width = 8,
	parameter int Depth = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/bit_vector_range_engine.sv
// Get and put visit the one byte that holds the bit; range requests walk each covered byte, and
// count walks each byte covering the vector length, through CHECK, READ, STEP per byte and FINISH.
// Rejected requests and count over zero length go from CHECK straight to FINISH.
// Busy holds through the done beat, so a new request is taken only after the last one is through.
// The byte walk of the single read-modify-write unit over the store sets the throughput.
// Reset clears the store at once through per-byte valid bits; length resets to 1024.
module bit_vector_range_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bvre_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                kind,
	input  logic [bvre_pkg::IdxW-1:0] index_low,
	input  logic [bvre_pkg::IdxW-1:0] index_high,
	input  logic                      bit_value,
	output logic                      done,
	output logic                      bit_out,
	output logic [bvre_pkg::PopW-1:0] population,
	output logic                      error
);

	import bvre_pkg::*;

	state_t state_q, state_d;

	logic [LenW-1:0]       len_q;
	logic [2:0]            kind_q;
	logic [IdxW-1:0]       lo_q, hi_q;
	logic                  bv_q;
	logic [AddrW-1:0]      addr_q, cur_q, last_q;
	logic [StoreBytes-1:0] valid_q;
	logic                  bit_q, err_q;
	logic [PopW-1:0]       pop_q;

	logic [LenW-1:0]  len_sat;
	logic [LenW-1:0]  cnt_bytes;
	logic             chk_err, cnt_empty, accept, cfg_we;
	logic [AddrW-1:0] first_byte, last_byte;
	logic [7:0]       rdata, byte_d, mask, bit_mask, new_byte;
	logic             ram_we;

	assign accept = start && !busy;
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = {{(32 - LenW){1'b0}}, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LenW'(MaxBits);
		end else if (cfg_we && paddr[PaddrW-1:2] == '0) begin
			len_q <= pwdata[LenW-1:0];
		end
	end

	assign len_sat   = (len_q > LenW'(MaxBits)) ? LenW'(MaxBits) : len_q;
	assign cnt_bytes = (len_sat + LenW'(7)) >> 3;
	assign cnt_empty = (cnt_bytes == '0);

	always_comb begin
		unique case (kind_q)
			KIND_GET, KIND_PUT:
				chk_err = ({1'b0, lo_q} >= len_sat);
			KIND_CLEAR, KIND_SET, KIND_INVERT:
				chk_err = ({1'b0, hi_q} >= len_sat) || (lo_q > hi_q);
			KIND_COUNT:
				chk_err = 1'b0;
			default:
				chk_err = 1'b1;
		endcase
	end

	always_comb begin
		if (kind_q == KIND_COUNT) begin
			first_byte = '0;
			last_byte  = AddrW'(cnt_bytes - LenW'(1));
		end else if (kind_q == KIND_GET || kind_q == KIND_PUT) begin
			first_byte = lo_q[IdxW-1:3];
			last_byte  = lo_q[IdxW-1:3];
		end else begin
			first_byte = lo_q[IdxW-1:3];
			last_byte  = hi_q[IdxW-1:3];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (chk_err || (kind_q == KIND_COUNT && cnt_empty)) state_d = ST_FINISH;
				else state_d = ST_READ;
			end
			ST_READ: state_d = ST_STEP;
			ST_STEP: begin
				if (cur_q == last_q) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != ST_IDLE);
		done   = (state_q == ST_FINISH);
		ram_we = (state_q == ST_STEP) && (kind_q != KIND_GET) && (kind_q != KIND_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	bvre_ram #(
		.Width(8),
		.Depth(StoreBytes)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_q),
		.wdata(new_byte),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign byte_d   = valid_q[cur_q] ? rdata : 8'h00;
	assign bit_mask = 8'h01 << lo_q[2:0];

	always_comb begin
		mask = 8'hFF;
		if (cur_q == lo_q[IdxW-1:3]) mask = mask & (8'hFF << lo_q[2:0]);
		if (cur_q == hi_q[IdxW-1:3]) mask = mask & (8'hFF >> (3'd7 - hi_q[2:0]));
	end

	always_comb begin
		case (kind_q)
			KIND_PUT:    new_byte = bv_q ? (byte_d | bit_mask) : (byte_d & ~bit_mask);
			KIND_CLEAR:  new_byte = byte_d & ~mask;
			KIND_SET:    new_byte = byte_d | mask;
			KIND_INVERT: new_byte = byte_d ^ mask;
			default:     new_byte = byte_d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[cur_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			lo_q   <= index_low;
			hi_q   <= index_high;
			bv_q   <= bit_value;
		end
		unique case (state_q)
			ST_CHECK: begin
				addr_q <= first_byte;
				last_q <= last_byte;
				bit_q  <= 1'b0;
				pop_q  <= '0;
				err_q  <= chk_err;
			end
			ST_READ: begin
				cur_q  <= addr_q;
				addr_q <= addr_q + AddrW'(1);
			end
			ST_STEP: begin
				cur_q  <= addr_q;
				addr_q <= addr_q + AddrW'(1);
				if (kind_q == KIND_GET || kind_q == KIND_PUT) begin
					bit_q <= byte_d[lo_q[2:0]];
				end
				if (kind_q == KIND_COUNT) begin
					pop_q <= pop_q + PopW'(ones_in_byte(byte_d));
				end
			end
			default: begin
			end
		endcase
	end

	assign bit_out    = bit_q;
	assign population = pop_q;
	assign error      = err_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy not raised after accept");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after done beat");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && error |-> population == '0 && !bit_out)
		else $error("rejected request returned data");
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy && !err_q) else $error("store written outside a valid request");

endmodule
